[design/wflc_pkg.sv]
// Package with shared types, constants and the sine table helper.
`default_nettype none
package wflc_pkg;

    localparam int HARMONICS_DEF  = 2;
    localparam int SINE_DEPTH_DEF = 256;

    localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

    localparam int ACC_Y_W = 56;
    localparam int ACC_Z_W = 58;

    localparam logic [1:0] CFG_FREQ_GAIN   = 2'd0;
    localparam logic [1:0] CFG_WEIGHT_GAIN = 2'd1;
    localparam logic [1:0] CFG_START_FREQ  = 2'd2;

    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef struct packed {
        logic               op;
        logic signed [15:0] sample;
        logic [23:0]        time_step;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] estimate;
        logic [31:0]        frequency_now;
    } t_out_word;

    typedef enum logic [4:0] {
        ST_IDLE, ST_PROD, ST_INC_LO, ST_INC_HI, ST_PHASE,
        ST_RD_S, ST_RD_C, ST_Y_S, ST_Y_C, ST_Z_C, ST_Z_S,
        ST_ERR, ST_GAIN, ST_WGAIN, ST_TE_LO, ST_TE_HI, ST_FREQ,
        ST_UP_RD, ST_UP_S, ST_UP_C, ST_UP_WR, ST_DONE
    } t_state;

    // Taylor series of sine to x^13 in Q2.30, rounded to Q15 and capped.
    function automatic logic [14:0] taylor_q15(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] q;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + term;
        q = (sum + 64'd16384) >> 15;
        return (q > 64'd32767) ? 15'd32767 : q[14:0];
    endfunction

endpackage
`default_nettype wire

[design/wflc_adaptive_tremor_filter_top.sv]
// Top level of the adaptive tremor filter: sequencer, arithmetic and handshakes.
//
//  channel   direction  handshake                     word
//  input     in         i_in_valid / o_in_stall       wflc_pkg::t_in_word
//  output    out        o_out_valid / i_out_stall     wflc_pkg::t_out_word
//  config    in         i_cfg_we                      i_cfg_idx, i_cfg_data
//
// A sample word makes one pass over the weight memory with a single read port for
// the estimate, then a second read-modify-write pass for the weight update. A
// restart word is taken in the idle state, which the sequencer does not leave.
// Reset is synchronous and active low; it clears the weights, phase and frequency.
// The result sits in an output register, so a stalled output only holds the
// sequencer when the next result is ready before the previous one is taken.
`default_nettype none
module wflc_adaptive_tremor_filter_top #(
    parameter int HARMONICS        = wflc_pkg::HARMONICS_DEF,
    parameter int SINE_TABLE_DEPTH = wflc_pkg::SINE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire wflc_pkg::t_in_word i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output wflc_pkg::t_out_word     o_out_data,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data
);
    import wflc_pkg::*;

    localparam int HW = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
    localparam int AW = $clog2(2 * HARMONICS);

    t_state r_state, n_state;

    logic [15:0] r_fg, r_wg;
    logic [31:0] r_sf;
    logic [31:0] r_freq, r_phase, r_hph, r_inc;
    logic signed [15:0] r_smp;
    logic [23:0] r_dt;
    logic [55:0] r_p;
    logic [61:0] r_lo;
    logic [HW-1:0] r_h;
    logic signed [31:0] r_w, r_v;
    logic signed [15:0] r_s, r_c;
    logic signed [19:0] r_cs, r_ss;
    logic signed [15:0] r_sv [HARMONICS];
    logic signed [15:0] r_cv [HARMONICS];
    logic signed [ACC_Y_W-1:0] r_acc_y;
    logic signed [ACC_Z_W-1:0] r_acc_z;
    logic signed [32:0] r_err;
    logic signed [15:0] r_est;
    logic signed [31:0] r_z;
    logic signed [32:0] r_t;
    logic signed [49:0] r_m;
    logic signed [66:0] r_te;
    logic signed [44:0] r_g;
    logic r_ovalid;
    t_out_word r_odata;

    logic w_last;
    logic w_in_acc;
    logic w_out_load;
    logic w_mem_we;
    logic [AW-1:0] w_mem_waddr, w_mem_raddr;
    logic signed [31:0] w_mem_wdata, w_rdata;
    logic signed [15:0] w_sin, w_cos;

    assign w_last   = (r_h == HW'(HARMONICS - 1));
    assign w_in_acc = i_in_valid && !o_in_stall;

    wflc_wmem #(.ENTRIES(2 * HARMONICS)) u_wmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_in_acc && i_in_data.op == OP_RESTART),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_rdata)
    );

    wflc_trig #(.DEPTH(SINE_TABLE_DEPTH)) u_trig (
        .i_clk   (i_clk),
        .i_phase (r_hph),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_in_acc && i_in_data.op == OP_SAMPLE) n_state = ST_PROD;
            ST_PROD:   n_state = ST_INC_LO;
            ST_INC_LO: n_state = ST_INC_HI;
            ST_INC_HI: n_state = ST_PHASE;
            ST_PHASE:  n_state = ST_RD_S;
            ST_RD_S:   n_state = ST_RD_C;
            ST_RD_C:   n_state = ST_Y_S;
            ST_Y_S:    n_state = ST_Y_C;
            ST_Y_C:    n_state = ST_Z_C;
            ST_Z_C:    n_state = ST_Z_S;
            ST_Z_S:    n_state = w_last ? ST_ERR : ST_RD_S;
            ST_ERR:    n_state = ST_GAIN;
            ST_GAIN:   n_state = ST_WGAIN;
            ST_WGAIN:  n_state = ST_TE_LO;
            ST_TE_LO:  n_state = ST_TE_HI;
            ST_TE_HI:  n_state = ST_FREQ;
            ST_FREQ:   n_state = ST_UP_RD;
            ST_UP_RD:  n_state = ST_UP_S;
            ST_UP_S:   n_state = ST_UP_C;
            ST_UP_C:   n_state = ST_UP_WR;
            ST_UP_WR:  n_state = w_last ? ST_DONE : ST_UP_RD;
            ST_DONE:   if (!r_ovalid || !i_out_stall) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        w_mem_we    = 1'b0;
        w_mem_waddr = AW'({r_h, 1'b0});
        w_mem_raddr = AW'({r_h, 1'b0});
        w_out_load  = 1'b0;
        unique case (r_state)
            ST_RD_C, ST_UP_S: w_mem_raddr = AW'({r_h, 1'b1});
            ST_UP_C:          w_mem_we = 1'b1;
            ST_UP_WR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = AW'({r_h, 1'b1});
            end
            ST_DONE:          w_out_load = !r_ovalid || !i_out_stall;
            default: ;
        endcase
    end

    // Weight update with saturation to 32-bit signed.
    logic signed [45:0] w_wsum;
    always_comb begin
        w_wsum = (r_state == ST_UP_C) ? 46'(r_w) + 46'(r_g) : 46'(r_v) + 46'(r_g);
        if (w_wsum > 46'sh7fff_ffff) begin
            w_mem_wdata = 32'sh7fff_ffff;
        end else if (w_wsum < -46'sh8000_0000) begin
            w_mem_wdata = -32'sh8000_0000;
        end else begin
            w_mem_wdata = 32'(w_wsum);
        end
    end

    // Rounded and saturated intermediate values.
    logic [HW:0] w_hp1;
    logic signed [19:0] w_hp1_s;
    logic signed [ACC_Y_W-1:0] w_ysh;
    logic signed [31:0] w_y;
    logic signed [ACC_Z_W-1:0] w_zsh;
    logic signed [48:0] w_tprod;
    logic signed [66:0] w_dsh, w_f;
    logic signed [65:0] w_gp;
    logic [53:0] w_hi;

    assign w_hp1   = (HW + 1)'(r_h) + (HW + 1)'(1);
    assign w_hp1_s = 20'($signed({1'b0, w_hp1}));
    assign w_ysh   = (r_acc_y + ACC_Y_W'(64'sd8388608)) >>> 24;
    assign w_y     = 32'(w_ysh);
    assign w_zsh   = (r_acc_z + ACC_Z_W'(64'sd16384)) >>> 15;
    assign w_tprod = 49'($signed({1'b0, r_fg})) * 49'(r_z);
    assign w_dsh   = (r_te + 67'sd2097152) >>> 22;
    assign w_f     = 67'($signed({1'b0, r_freq})) + w_dsh;
    assign w_gp    = 66'(r_m) * 66'((r_state == ST_UP_S) ? r_sv[r_h] : r_cv[r_h]);
    assign w_hi    = 54'(r_p[55:32]) * 54'(INV_TWO_PI_Q32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fg     <= '0;
            r_wg     <= '0;
            r_sf     <= '0;
            r_freq   <= '0;
            r_phase  <= '0;
            r_ovalid <= 1'b0;
            r_h      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FREQ_GAIN:   r_fg <= i_cfg_data[15:0];
                    CFG_WEIGHT_GAIN: r_wg <= i_cfg_data[15:0];
                    CFG_START_FREQ:  r_sf <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && i_in_data.op == OP_RESTART) begin
                        r_freq  <= r_sf;
                        r_phase <= '0;
                    end
                end
                ST_PHASE: begin
                    r_phase <= r_phase + r_inc;
                    r_h     <= '0;
                end
                ST_Z_S:   r_h <= w_last ? '0 : r_h + HW'(1);
                ST_FREQ: begin
                    if (w_f < 67'sd0) begin
                        r_freq <= '0;
                    end else if (w_f > 67'sh0_ffff_ffff) begin
                        r_freq <= 32'hffff_ffff;
                    end else begin
                        r_freq <= w_f[31:0];
                    end
                end
                ST_UP_WR: r_h <= w_last ? '0 : r_h + HW'(1);
                default: ;
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_smp <= i_in_data.sample;
                r_dt  <= i_in_data.time_step;
            end
            ST_PROD:   r_p  <= 56'(r_freq) * 56'(r_dt);
            ST_INC_LO: r_lo <= 62'(r_p[31:0]) * 62'(INV_TWO_PI_Q32);
            ST_INC_HI: r_inc <= 32'((w_hi + 54'(r_lo[61:32])) >> 8);
            ST_PHASE: begin
                r_hph   <= r_phase + r_inc;
                r_acc_y <= '0;
                r_acc_z <= '0;
            end
            ST_RD_C: begin
                r_w       <= w_rdata;
                r_s       <= w_sin;
                r_c       <= w_cos;
                r_sv[r_h] <= w_sin;
                r_cv[r_h] <= w_cos;
                r_cs      <= w_hp1_s * 20'(w_cos);
                r_ss      <= w_hp1_s * 20'(w_sin);
            end
            ST_Y_S: begin
                r_v     <= w_rdata;
                r_acc_y <= r_acc_y + ACC_Y_W'(r_w) * ACC_Y_W'(r_s);
            end
            ST_Y_C: r_acc_y <= r_acc_y + ACC_Y_W'(r_v) * ACC_Y_W'(r_c);
            ST_Z_C: r_acc_z <= r_acc_z + ACC_Z_W'(r_w) * ACC_Z_W'(r_cs);
            ST_Z_S: begin
                r_acc_z <= r_acc_z - ACC_Z_W'(r_v) * ACC_Z_W'(r_ss);
                r_hph   <= r_hph + r_phase;
            end
            ST_ERR: begin
                r_err <= 33'(r_smp) - 33'(w_y);
                if (w_y > 32'sd32767) begin
                    r_est <= 16'sh7fff;
                end else if (w_y < -32'sd32768) begin
                    r_est <= -16'sh8000;
                end else begin
                    r_est <= 16'(w_y);
                end
                if (w_zsh > ACC_Z_W'(64'sh7fff_ffff)) begin
                    r_z <= 32'sh7fff_ffff;
                end else if (w_zsh < ACC_Z_W'(-64'sh8000_0000)) begin
                    r_z <= -32'sh8000_0000;
                end else begin
                    r_z <= 32'(w_zsh);
                end
            end
            ST_GAIN:  r_t <= 33'((w_tprod + 49'sd32768) >>> 16);
            ST_WGAIN: r_m <= 50'($signed({1'b0, r_wg})) * 50'(r_err);
            ST_TE_LO: r_te <= 67'(r_t) * 67'($signed({1'b0, r_err[15:0]}));
            ST_TE_HI: r_te <= r_te + ((67'(r_t) * 67'($signed(r_err[32:16]))) <<< 16);
            ST_UP_S: begin
                r_w <= w_rdata;
                r_g <= 45'((w_gp + 66'sd1048576) >>> 21);
            end
            ST_UP_C: begin
                r_v <= w_rdata;
                r_g <= 45'((w_gp + 66'sd1048576) >>> 21);
            end
            ST_DONE: begin
                if (w_out_load) begin
                    r_odata.estimate      <= r_est;
                    r_odata.frequency_now <= r_freq;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
endmodule
`default_nettype wire

[design/wflc_wmem.sv]
// Weight memory: one write port, one registered read port, entries read as zero until written.
`default_nettype none
module wflc_wmem #(
    parameter int ENTRIES = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_clear,
    input  wire logic                       i_we,
    input  wire logic [$clog2(ENTRIES)-1:0] i_waddr,
    input  wire logic signed [31:0]         i_wdata,
    input  wire logic [$clog2(ENTRIES)-1:0] i_raddr,
    output logic signed [31:0]              o_rdata
);
    logic signed [31:0] r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic signed [31:0] r_rdata;
    logic               r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : 32'sd0;
endmodule
`default_nettype wire

[design/wflc_trig.sv]
// Quarter-wave table lookup giving registered sine and cosine of a phase.
`default_nettype none
module wflc_trig #(
    parameter int DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_phase,
    output logic signed [15:0] o_sin,
    output logic signed [15:0] o_cos
);
    import wflc_pkg::*;

    localparam int IW = $clog2(DEPTH + 1);
    localparam int PW = 30 + IW;

    logic [14:0] w_tbl [DEPTH + 1];

    for (genvar gi = 0; gi <= DEPTH; gi++) begin : g_tbl
        localparam logic [63:0] X = (64'(gi) * HALF_PI_Q30) / 64'(DEPTH);
        assign w_tbl[gi] = taylor_q15(X);
    end

    function automatic logic signed [15:0] lookup(input logic [31:0] ph,
                                                  input logic [14:0] tbl [DEPTH + 1]);
        logic [PW-1:0]  prod;
        logic [IW-1:0]  idx;
        logic [14:0]    mag;
        prod = PW'(ph[29:0]) * PW'(DEPTH);
        idx  = prod[PW-1:30];
        mag  = ph[30] ? tbl[IW'(DEPTH) - idx] : tbl[idx];
        return ph[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    logic [31:0] w_cph;
    assign w_cph = i_phase + 32'h4000_0000;

    always_ff @(posedge i_clk) begin
        o_sin <= lookup(i_phase, w_tbl);
        o_cos <= lookup(w_cph, w_tbl);
    end
endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the adaptive tremor filter, with a fixed-point predictor.
`timescale 1ns / 100ps
module tb_top;
    import wflc_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int N_HARM      = 2;
    localparam int SETTLE      = 64;
    localparam int IDLE_LIMIT  = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_word    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_word   o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    logic hold_output = 1'b0;
    logic calm = 1'b0;
    int   idle_cycles = 0;

    wflc_adaptive_tremor_filter_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    class tremor_scoreboard;
        int          quarter_sine[TABLE_DEPTH + 1];
        logic [15:0] mu_freq;
        logic [15:0] mu_weight;
        logic [31:0] freq_on_restart;
        logic [31:0] omega;
        logic [31:0] phase;
        int          w_sin[N_HARM];
        int          w_cos[N_HARM];
        t_out_word   expected_words[$];
        int          errors;
        int          samples;
        int          restarts;
        int          results;

        function new();
            longint unsigned x, x2, term, acc, q;
            for (int i = 0; i <= TABLE_DEPTH; i++) begin
                x = (longint'(i) * 64'd1686629713) / TABLE_DEPTH;
                x2 = (x * x) >> 30;
                term = x;
                acc = x;
                for (int k = 1; k <= 6; k++) begin
                    term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                    if (k % 2 == 1) begin
                        acc = acc - term;
                    end else begin
                        acc = acc + term;
                    end
                end
                q = (acc + 64'd16384) >> 15;
                quarter_sine[i] = (q > 32767) ? 32767 : int'(q);
            end
            errors = 0;
            samples = 0;
            restarts = 0;
            results = 0;
            clear_all();
        endfunction

        function void clear_all();
            mu_freq = '0;
            mu_weight = '0;
            freq_on_restart = '0;
            omega = '0;
            phase = '0;
            foreach (w_sin[h]) begin
                w_sin[h] = 0;
                w_cos[h] = 0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                CFG_FREQ_GAIN: begin
                    mu_freq = value[15:0];
                end
                CFG_WEIGHT_GAIN: begin
                    mu_weight = value[15:0];
                end
                CFG_START_FREQ: begin
                    freq_on_restart = value;
                end
                default: ;
            endcase
        endfunction

        function longint round_shift(longint v, int n);
            return (v + (longint'(1) <<< (n - 1))) >>> n;
        endfunction

        function longint sine_at(logic [31:0] ph);
            int idx;
            longint mag;
            idx = ph[29:22];
            mag = ph[30] ? quarter_sine[TABLE_DEPTH - idx] : quarter_sine[idx];
            return ph[31] ? -mag : mag;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function void note_input(t_in_word w);
            longint unsigned prod, lo, hi;
            longint s[N_HARM], c[N_HARM];
            longint y_acc, z_acc, y, err, z, t, f, smp;
            logic [31:0] ph;
            t_out_word exp_word;
            if (w.op == OP_RESTART) begin
                restarts++;
                omega = freq_on_restart;
                phase = '0;
                foreach (w_sin[h]) begin
                    w_sin[h] = 0;
                    w_cos[h] = 0;
                end
                return;
            end
            samples++;
            smp = longint'($signed(w.sample));
            prod = longint'(omega) * longint'(w.time_step);
            lo = (prod & 64'hffff_ffff) * 64'd683565276;
            hi = (prod >> 32) * 64'd683565276;
            phase = phase + 32'((hi + (lo >> 32)) >> 8);
            y_acc = 0;
            z_acc = 0;
            for (int h = 0; h < N_HARM; h++) begin
                ph = 32'(longint'(h + 1) * longint'(phase));
                s[h] = sine_at(ph);
                c[h] = sine_at(ph + 32'h4000_0000);
                y_acc += longint'(w_sin[h]) * s[h] + longint'(w_cos[h]) * c[h];
                z_acc += longint'(h + 1) *
                         (longint'(w_sin[h]) * c[h] - longint'(w_cos[h]) * s[h]);
            end
            y = round_shift(y_acc, 24);
            err = smp - y;
            z = clamp32(round_shift(z_acc, 15));
            t = round_shift(longint'(mu_freq) * z, 16);
            f = longint'(omega) + round_shift(t * err, 22);
            if (f < 0) f = 0;
            if (f > 64'sh0_ffff_ffff) f = 64'sh0_ffff_ffff;
            omega = f[31:0];
            for (int h = 0; h < N_HARM; h++) begin
                w_sin[h] = int'(clamp32(longint'(w_sin[h]) +
                               round_shift(longint'(mu_weight) * s[h] * err, 21)));
                w_cos[h] = int'(clamp32(longint'(w_cos[h]) +
                               round_shift(longint'(mu_weight) * c[h] * err, 21)));
            end
            exp_word.estimate = (y > 32767) ? 16'sh7fff : ((y < -32768) ? 16'sh8000 : y[15:0]);
            exp_word.frequency_now = omega;
            expected_words.push_back(exp_word);
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40) $display("MISMATCH at %0t: %s", $time, what);
        endtask

        task check_result(t_out_word got);
            t_out_word exp_word;
            results++;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected word est=%0d freq=%0d",
                                 got.estimate, got.frequency_now));
                return;
            end
            exp_word = expected_words.pop_front();
            if (got.estimate !== exp_word.estimate)
                report($sformatf("estimate %0d, expected %0d",
                                 got.estimate, exp_word.estimate));
            if (got.frequency_now !== exp_word.frequency_now)
                report($sformatf("frequency %0d, expected %0d",
                                 got.frequency_now, exp_word.frequency_now));
        endtask
    endclass

    tremor_scoreboard sb = new();

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 45);
    endfunction

    // Output side: random stalls plus one long hold-off requested by the stimulus.
    initial begin
        int hold;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_output) begin
                i_out_stall <= 1'b1;
                hold = 400;
                while (hold > 0) begin
                    @(posedge i_clk);
                    hold--;
                end
                hold_output <= 1'b0;
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= (gap_len() != 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // The enable drops for one cycle between writes.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge i_clk);
    endtask

    // Valid stays high after acceptance; only a gap or a drain lowers it.
    task automatic send_word(t_in_word w);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data <= w;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(w);
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_words.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_in_word make_word(logic op, int smp, int dt);
        t_in_word w;
        w.op = op;
        w.sample = smp[15:0];
        w.time_step = dt[23:0];
        return w;
    endfunction

    function automatic t_in_word random_word();
        int r;
        int smp;
        int dt;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            smp = $urandom_range(0, 8000) - 4000;
        end else if (r < 92) begin
            smp = $urandom_range(0, 65535);
        end else begin
            smp = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
        end
        r = $urandom_range(0, 99);
        if (r < 80) begin
            dt = $urandom_range(1000, 40000);
        end else if (r < 95) begin
            dt = $urandom_range(0, 24'hffffff);
        end else begin
            dt = ($urandom_range(0, 1) != 0) ? 24'hffffff : 0;
        end
        return make_word(($urandom_range(0, 99) < 3) ? OP_RESTART : OP_SAMPLE, smp, dt);
    endfunction

    initial begin
        logic [15:0] mu0_set[6] = '{16'd0, 16'd65535, 16'd300, 16'd4000, 16'd0, 16'd1};
        logic [15:0] mu1_set[6] = '{16'd0, 16'd65535, 16'd3000, 16'd20000, 16'd65535, 16'd1};
        logic [31:0] f0_set[6]  = '{32'd0, 32'hffff_ffff, 32'd3294199, 32'd1000000,
                                    32'd65536, 32'd0};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: a step before any configuration, then field extremes.
        send_word(make_word(OP_SAMPLE, 1234, 5000));
        drain();
        write_reg(CFG_FREQ_GAIN, 32'd2000);
        write_reg(CFG_WEIGHT_GAIN, 32'd30000);
        write_reg(CFG_START_FREQ, 32'd3294199);
        write_reg(2'd3, 32'hdead_beef);
        send_word(make_word(OP_RESTART, 777, 999));
        send_word(make_word(OP_SAMPLE, 32767, 16777));
        send_word(make_word(OP_SAMPLE, -32768, 16777));
        send_word(make_word(OP_SAMPLE, 0, 0));
        send_word(make_word(OP_SAMPLE, 32767, 24'hffffff));
        send_word(make_word(OP_SAMPLE, -32768, 1));
        send_word(make_word(OP_SAMPLE, -1, 24'hffffff));
        send_word(make_word(OP_RESTART, -32768, 24'hffffff));
        send_word(make_word(OP_SAMPLE, 16384, 24'h800000));
        send_word(make_word(OP_SAMPLE, -16384, 24'h7fffff));
        for (int i = 0; i < 8; i++) send_word(make_word(OP_SAMPLE, 32767, 24'hffffff));
        drain();

        for (int p = 0; p < 6; p++) begin
            if (p == 5) begin
                write_reg(CFG_FREQ_GAIN, $urandom_range(0, 65535));
                write_reg(CFG_WEIGHT_GAIN, $urandom_range(0, 65535));
                write_reg(CFG_START_FREQ, $urandom());
            end else begin
                write_reg(CFG_FREQ_GAIN, mu0_set[p]);
                write_reg(CFG_WEIGHT_GAIN, mu1_set[p]);
                write_reg(CFG_START_FREQ, f0_set[p]);
            end
            send_word(make_word(OP_RESTART, 0, 0));
            for (int i = 0; i < 235; i++) begin
                if (i % 40 == 0) calm <= ($urandom_range(0, 3) == 0);
                if (p == 2 && i == 60) hold_output <= 1'b1;
                send_word(random_word());
            end
            calm <= 1'b0;
            drain();
        end

        $display("Covered %0d sample words and %0d restarts, %0d results checked,",
                 sb.samples, sb.restarts, sb.results);
        $display("over zero, full-scale and mid gain settings with output back-pressure.");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
